@@ design/psa_pkg.sv @@
`timescale 1ns / 1ps
package psa_pkg;

   localparam int PoolSize   = 1024;
   localparam int SlotWidth  = $clog2(PoolSize);
   localparam int CountWidth = SlotWidth + 1;
   localparam int WordBits   = 32;
   localparam int BitWidth   = $clog2(WordBits);
   localparam int RowCount   = PoolSize / WordBits;
   localparam int RowWidth   = $clog2(RowCount);

   localparam logic [1:0] StatusDone    = 2'd0;
   localparam logic [1:0] StatusFull    = 2'd1;
   localparam logic [1:0] StatusZeroVel = 2'd2;
   localparam logic [1:0] StatusBadPos  = 2'd3;

   localparam logic CmdAlloc = 1'b0;
   localparam logic CmdFree  = 1'b1;

   localparam logic [1:0] OpAlloc   = 2'd0;
   localparam logic [1:0] OpAllocZv = 2'd1;
   localparam logic [1:0] OpFree    = 2'd2;

   typedef struct packed {
      logic                 cmd;
      logic [SlotWidth-1:0] active_position;
      logic                 zero_velocity;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SlotWidth-1:0]  slot;
      logic [CountWidth-1:0] active_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [SlotWidth-1:0] position;
   } op_type;

endpackage

@@ design/psa_ram.sv @@
`timescale 1ns / 1ps
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ design/psa_front.sv @@
`timescale 1ns / 1ps
module psa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  psa_pkg::req_type  req_data,
   output logic              op_valid,
   input  logic              op_take,
   output psa_pkg::op_type   op_data
);

   psa_pkg::op_type entry_ff [2];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic [1:0]      fill_ff;
   logic [1:0]      fill_in;
   logic            accept;
   logic            release_op;
   psa_pkg::op_type decoded;

   assign full       = (fill_ff == 2'd2);
   assign accept     = push && !full;
   assign op_valid   = (fill_ff != 2'd0);
   assign release_op = op_take && op_valid;
   assign op_data    = entry_ff[rd_ptr_ff];

   // sort the command so the back end only has to check pool state
   always_comb begin
      decoded.position = req_data.active_position;
      if (req_data.cmd == psa_pkg::CmdFree) begin
         decoded.op = psa_pkg::OpFree;
      end else if (req_data.zero_velocity) begin
         decoded.op = psa_pkg::OpAllocZv;
      end else begin
         decoded.op = psa_pkg::OpAlloc;
      end
   end

   always_comb begin
      unique case ({accept, release_op})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (accept) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (release_op) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ design/psa_back.sv @@
`timescale 1ns / 1ps
module psa_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_take,
   input  psa_pkg::op_type  op_data,
   output logic             empty,
   input  logic             pop,
   output psa_pkg::rsp_type rsp_data
);

   localparam logic [2:0] StIdle         = 3'd0;
   localparam logic [2:0] StAllocRead    = 3'd1;
   localparam logic [2:0] StFreeReadPos  = 3'd2;
   localparam logic [2:0] StFreeReadLast = 3'd3;
   localparam logic [2:0] StResult       = 3'd4;

   localparam int SlotW  = psa_pkg::SlotWidth;
   localparam int CountW = psa_pkg::CountWidth;
   localparam int WordW  = psa_pkg::WordBits;
   localparam int BitW   = psa_pkg::BitWidth;
   localparam int RowN   = psa_pkg::RowCount;
   localparam int RowW   = psa_pkg::RowWidth;

   logic [2:0]        state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [RowN-1:0]   summary_ff, summary_in;
   logic [RowN-1:0]   row_valid_ff, row_valid_in;
   logic [SlotW-1:0]  position_ff, position_in;
   logic [RowW-1:0]   map_row_ff, map_row_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   psa_pkg::rsp_type  result_ff, result_in;

   psa_pkg::rsp_type  out_entry_ff [2];
   logic              out_wr_ptr_ff;
   logic              out_rd_ptr_ff;
   logic [1:0]        out_fill_ff, out_fill_in;
   logic              out_full;
   logic              out_push;
   logic              out_pop;

   logic              list_wr_en;
   logic [SlotW-1:0]  list_wr_addr;
   logic [SlotW-1:0]  list_wr_data;
   logic              list_rd_en;
   logic [SlotW-1:0]  list_rd_addr;
   logic [SlotW-1:0]  list_rd_data;

   logic              map_wr_en;
   logic [RowW-1:0]   map_wr_addr;
   logic [WordW-1:0]  map_wr_data;
   logic              map_rd_en;
   logic [RowW-1:0]   map_rd_addr;
   logic [WordW-1:0]  map_rd_data;

   logic              free_row_hit;
   logic [RowW-1:0]   free_row;
   logic [WordW-1:0]  map_word;
   logic              free_bit_hit;
   logic [BitW-1:0]   free_bit;
   logic [WordW-1:0]  alloc_word;
   logic [WordW-1:0]  release_word;
   logic              pool_full;
   logic [RowW-1:0]   freed_row;

   function automatic psa_pkg::rsp_type pack_rsp(input logic [1:0] status,
                                                 input logic [SlotW-1:0] slot,
                                                 input logic [CountW-1:0] cnt);
      psa_pkg::rsp_type r;
      r.status       = status;
      r.slot         = slot;
      r.active_count = cnt;
      return r;
   endfunction

   psa_ram #(.WIDTH(SlotW), .DEPTH(psa_pkg::PoolSize)) u_list_ram (
      .clock         (clock),
      .write_enable  (list_wr_en),
      .write_address (list_wr_addr),
      .write_data    (list_wr_data),
      .read_enable   (list_rd_en),
      .read_address  (list_rd_addr),
      .read_data     (list_rd_data)
   );

   psa_ram #(.WIDTH(WordW), .DEPTH(RowN)) u_map_ram (
      .clock         (clock),
      .write_enable  (map_wr_en),
      .write_address (map_wr_addr),
      .write_data    (map_wr_data),
      .read_enable   (map_rd_en),
      .read_address  (map_rd_addr),
      .read_data     (map_rd_data)
   );

   // lowest row that still has a clear bit
   always_comb begin
      free_row_hit = 1'b0;
      free_row     = '0;
      for (int r = RowN - 1; r >= 0; r--) begin
         if (!summary_ff[r]) begin
            free_row_hit = 1'b1;
            free_row     = RowW'(r);
         end
      end
   end

   // a row never written since reset reads as all free
   assign map_word = row_valid_ff[map_row_ff] ? map_rd_data : '0;

   always_comb begin
      free_bit_hit = 1'b0;
      free_bit     = '0;
      for (int b = WordW - 1; b >= 0; b--) begin
         if (!map_word[b]) begin
            free_bit_hit = 1'b1;
            free_bit     = BitW'(b);
         end
      end
   end

   assign alloc_word   = map_word | (WordW'(1) << free_bit);
   assign release_word = map_word & ~(WordW'(1) << slot_ff[BitW-1:0]);
   assign pool_full    = (count_ff == CountW'(psa_pkg::PoolSize));
   assign freed_row    = list_rd_data[SlotW-1 -: RowW];

   assign out_full = (out_fill_ff == 2'd2);
   assign out_push = (state_ff == StResult) && !out_full;
   assign out_pop  = pop && !empty;
   assign empty    = (out_fill_ff == 2'd0);
   assign rsp_data = out_entry_ff[out_rd_ptr_ff];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      summary_in   = summary_ff;
      row_valid_in = row_valid_ff;
      position_in  = position_ff;
      map_row_in   = map_row_ff;
      slot_in      = slot_ff;
      result_in    = result_ff;
      op_take      = 1'b0;
      list_wr_en   = 1'b0;
      list_wr_addr = '0;
      list_wr_data = '0;
      list_rd_en   = 1'b0;
      list_rd_addr = '0;
      map_wr_en    = 1'b0;
      map_wr_addr  = '0;
      map_wr_data  = '0;
      map_rd_en    = 1'b0;
      map_rd_addr  = '0;
      unique case (state_ff)
         StIdle: begin
            if (op_valid) begin
               op_take = 1'b1;
               if (op_data.op == psa_pkg::OpFree) begin
                  if ({1'b0, op_data.position} >= count_ff) begin
                     result_in = pack_rsp(psa_pkg::StatusBadPos, '0, count_ff);
                     state_in  = StResult;
                  end else begin
                     position_in  = op_data.position;
                     list_rd_en   = 1'b1;
                     list_rd_addr = op_data.position;
                     state_in     = StFreeReadPos;
                  end
               end else if (pool_full || !free_row_hit) begin
                  result_in = pack_rsp(psa_pkg::StatusFull, '0, count_ff);
                  state_in  = StResult;
               end else if (op_data.op == psa_pkg::OpAllocZv) begin
                  result_in = pack_rsp(psa_pkg::StatusZeroVel, '0, count_ff);
                  state_in  = StResult;
               end else begin
                  map_row_in  = free_row;
                  map_rd_en   = 1'b1;
                  map_rd_addr = free_row;
                  state_in    = StAllocRead;
               end
            end
         end
         StAllocRead: begin
            if (free_bit_hit) begin
               map_wr_en                = 1'b1;
               map_wr_addr              = map_row_ff;
               map_wr_data              = alloc_word;
               row_valid_in[map_row_ff] = 1'b1;
               summary_in[map_row_ff]   = &alloc_word;
               list_wr_en               = 1'b1;
               list_wr_addr             = count_ff[SlotW-1:0];
               list_wr_data             = {map_row_ff, free_bit};
               count_in                 = count_ff + CountW'(1);
               result_in = pack_rsp(psa_pkg::StatusDone, {map_row_ff, free_bit},
                                    count_ff + CountW'(1));
            end else begin
               result_in = pack_rsp(psa_pkg::StatusFull, '0, count_ff);
            end
            state_in = StResult;
         end
         StFreeReadPos: begin
            // fetch the tail entry and the bitmap row of the released slot
            slot_in      = list_rd_data;
            list_rd_en   = 1'b1;
            list_rd_addr = SlotW'(count_ff - CountW'(1));
            map_row_in   = freed_row;
            map_rd_en    = 1'b1;
            map_rd_addr  = freed_row;
            state_in     = StFreeReadLast;
         end
         StFreeReadLast: begin
            map_wr_en                = 1'b1;
            map_wr_addr              = map_row_ff;
            map_wr_data              = release_word;
            row_valid_in[map_row_ff] = 1'b1;
            summary_in[map_row_ff]   = 1'b0;
            // move the tail into the hole
            list_wr_en               = 1'b1;
            list_wr_addr             = position_ff;
            list_wr_data             = list_rd_data;
            count_in                 = count_ff - CountW'(1);
            result_in = pack_rsp(psa_pkg::StatusDone, slot_ff, count_ff - CountW'(1));
            state_in  = StResult;
         end
         StResult: begin
            if (!out_full) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      unique case ({out_push, out_pop})
         2'b10:   out_fill_in = out_fill_ff + 2'd1;
         2'b01:   out_fill_in = out_fill_ff - 2'd1;
         default: out_fill_in = out_fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         count_ff      <= '0;
         summary_ff    <= '0;
         row_valid_ff  <= '0;
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
         out_fill_ff   <= 2'd0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         summary_ff   <= summary_in;
         row_valid_ff <= row_valid_in;
         out_fill_ff  <= out_fill_in;
         if (out_push) begin
            out_wr_ptr_ff <= !out_wr_ptr_ff;
         end
         if (out_pop) begin
            out_rd_ptr_ff <= !out_rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      position_ff <= position_in;
      map_row_ff  <= map_row_in;
      slot_ff     <= slot_in;
      result_ff   <= result_in;
      if (out_push) begin
         out_entry_ff[out_wr_ptr_ff] <= result_ff;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(psa_pkg::PoolSize))
      else $error("active count above pool size");

   a_summary_rows: assert property (@(posedge clock) disable iff (reset)
      (summary_ff & ~row_valid_ff) == '0)
      else $error("row marked full but never written");

   a_alloc_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StAllocRead && free_bit_hit) |=>
      count_ff == $past(count_ff) + CountW'(1))
      else $error("grant did not grow the active list");

   a_free_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StFreeReadLast) |=> count_ff == $past(count_ff) - CountW'(1))
      else $error("release did not shrink the active list");
`endif

endmodule

@@ design/pool_slot_allocator.sv @@
`timescale 1ns / 1ps
// Allocator for a fixed pool of 1024 slots with a dense list of active slots.
// Allocate grants the lowest free slot and appends it to the list; free takes
// a list position, releases that slot and moves the last entry into the hole.
// Every command returns one transfer with status, slot and new active count.
// A two-entry command queue at the input and a two-entry result queue at the
// output let both sides stall independently. Commands run one at a time in the
// back-end sequencer, whose states follow the registered reads of the two RAMs
// (the bitmap row and the active list, which a free reads twice through its
// single read port). Bitmap rows carry valid flags cleared at reset, so no
// clearing pass is needed and the block accepts commands right after reset.
module pool_slot_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  psa_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output psa_pkg::rsp_type rsp_data
);

   logic            op_valid;
   logic            op_take;
   psa_pkg::op_type op_data;

   psa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_take  (op_take),
      .op_data  (op_data)
   );

   psa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_take  (op_take),
      .op_data  (op_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

@@ bench/psa_checker.sv @@
`timescale 1ns / 1ps
module psa_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  psa_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  psa_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   bit   [psa_pkg::PoolSize-1:0]   used_slots;
   logic [psa_pkg::SlotWidth-1:0]  slot_order [psa_pkg::PoolSize];
   logic [psa_pkg::CountWidth-1:0] live_count;
   psa_pkg::rsp_type               expected_rsp [$];

   // Apply one command to the shadow pool and return the transfer it yields.
   function automatic psa_pkg::rsp_type run_command(input psa_pkg::req_type r);
      psa_pkg::rsp_type              res;
      bit                            found;
      logic [psa_pkg::SlotWidth-1:0] pick;
      res.status = psa_pkg::StatusDone;
      res.slot   = '0;
      found      = 1'b0;
      pick       = '0;
      if (r.cmd == psa_pkg::CmdAlloc) begin
         if (live_count >= psa_pkg::PoolSize) begin
            res.status = psa_pkg::StatusFull;
         end else if (r.zero_velocity) begin
            res.status = psa_pkg::StatusZeroVel;
         end else begin
            for (int s = 0; s < psa_pkg::PoolSize; s++) begin
               if (!found && !used_slots[s]) begin
                  found = 1'b1;
                  pick  = s[psa_pkg::SlotWidth-1:0];
               end
            end
            if (found) begin
               used_slots[pick]       = 1'b1;
               slot_order[live_count] = pick;
               live_count             = live_count + 1'b1;
               res.slot               = pick;
            end else begin
               res.status = psa_pkg::StatusFull;
            end
         end
      end else begin
         if (r.active_position >= live_count) begin
            res.status = psa_pkg::StatusBadPos;
         end else begin
            pick = slot_order[r.active_position];
            used_slots[pick] = 1'b0;
            // swap the tail entry into the hole, then clear the tail
            slot_order[r.active_position] = slot_order[live_count - 1'b1];
            slot_order[live_count - 1'b1] = '0;
            live_count = live_count - 1'b1;
            res.slot   = pick;
         end
      end
      res.active_count = live_count;
      return res;
   endfunction

   always @(posedge clock) begin
      psa_pkg::rsp_type want;
      if (reset) begin
         used_slots = '0;
         for (int i = 0; i < psa_pkg::PoolSize; i++) slot_order[i] = '0;
         live_count = '0;
         expected_rsp.delete();
      end else begin
         if (pop && !empty) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected transfer: status %0d slot %0d count %0d",
                      rsp_data.status, rsp_data.slot, rsp_data.active_count);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
                  fail_count++;
               end
               if (rsp_data.active_count !== want.active_count) begin
                  $error("active_count: expected %0d, got %0d",
                         want.active_count, rsp_data.active_count);
                  fail_count++;
               end
            end
         end
         if (push && !full) begin
            expected_rsp.insert(expected_rsp.size(), run_command(req_data));
         end
      end
      pending = expected_rsp.size();
   end

endmodule

@@ bench/tb_pool_slot_allocator.sv @@
`timescale 1ns / 1ps
module tb_pool_slot_allocator;

   localparam int ItemTotal  = 1550;
   localparam int CycleLimit = 400000;
   localparam int HoldStart  = 300;
   localparam int HoldCycles = 500;

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   psa_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   psa_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;

   int               sent_total;
   int               level;
   int               burst_left;
   int               cycle_count;

   pool_slot_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   psa_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic psa_pkg::req_type make_req(input logic cmd, input int pos,
                                                 input logic zv);
      psa_pkg::req_type r;
      r.cmd             = cmd;
      r.active_position = pos[psa_pkg::SlotWidth-1:0];
      r.zero_velocity   = zv;
      return r;
   endfunction

   // Growth fills the pool, the full phase sits at the top, churn mixes everything.
   function automatic psa_pkg::req_type pick_random(input int phase, input int lvl);
      int roll;
      int junk;
      roll = $urandom_range(0, 99);
      junk = $urandom_range(0, psa_pkg::PoolSize - 1);
      if (phase == 1) return make_req(psa_pkg::CmdAlloc, junk, 1'($urandom_range(0, 1)));
      if (phase == 0) begin
         if (roll < 88 || lvl == 0) return make_req(psa_pkg::CmdAlloc, junk, 1'b0);
         if (roll < 91) return make_req(psa_pkg::CmdAlloc, junk, 1'b1);
         if (roll < 93 && lvl < psa_pkg::PoolSize)
            return make_req(psa_pkg::CmdFree, $urandom_range(lvl, psa_pkg::PoolSize - 1),
                            1'($urandom_range(0, 1)));
         return make_req(psa_pkg::CmdFree, $urandom_range(0, lvl - 1),
                         1'($urandom_range(0, 1)));
      end
      if (roll < 36) return make_req(psa_pkg::CmdAlloc, junk, 1'b0);
      if (roll < 40) return make_req(psa_pkg::CmdAlloc, junk, 1'b1);
      if ((roll >= 90 || lvl == 0) && lvl < psa_pkg::PoolSize)
         return make_req(psa_pkg::CmdFree, $urandom_range(lvl, psa_pkg::PoolSize - 1),
                         1'($urandom_range(0, 1)));
      if (lvl == 0) return make_req(psa_pkg::CmdAlloc, junk, 1'b0);
      return make_req(psa_pkg::CmdFree, $urandom_range(0, lvl - 1),
                      1'($urandom_range(0, 1)));
   endfunction

   // Hold the command until the block takes it, then track the list length.
   task automatic issue(input psa_pkg::req_type r);
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      sent_total++;
      if (r.cmd == psa_pkg::CmdAlloc) begin
         if (level < psa_pkg::PoolSize && !r.zero_velocity) level++;
      end else if (r.active_position < level) begin
         level--;
      end
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Receiver: stall pattern changes every stretch; one long hold-off fills the block.
   initial begin
      int  mode;
      int  span;
      int  tick;
      int  waited;
      bit  held;
      held = 1'b0;
      tick = 0;
      pop <= 1'b0;
      forever begin
         if (!held && sent_total >= HoldStart) begin
            held = 1'b1;
            pop <= 1'b0;
            for (waited = 0; waited < HoldCycles; waited++) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 80);
         repeat (span) begin
            case (mode)
               0: pop <= 1'b1;
               1: pop <= ($urandom_range(0, 9) < 7);
               2: pop <= ($urandom_range(0, 9) < 2);
               default: pop <= ((tick % 5) != 0);
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   initial begin
      psa_pkg::req_type directed [$];
      int               phase;
      int               full_items;
      reset      <= 1'b1;
      push       <= 1'b0;
      req_data   <= '0;
      sent_total = 0;
      level      = 0;
      burst_left = 0;
      phase      = 0;
      full_items = 0;

      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  1023, 1'b1));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b1));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 1023, 1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 512,  1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  1,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  3,    1'b1));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  3,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b1));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  2,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdFree,  0,    1'b0));
      directed.insert(directed.size(), make_req(psa_pkg::CmdAlloc, 0,    1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         issue(directed[i]);
         pace();
      end

      while (sent_total < ItemTotal || phase < 2) begin
         if (phase == 0 && level == psa_pkg::PoolSize) phase = 1;
         if (phase == 1 && full_items >= 16) phase = 2;
         if (phase == 1) full_items++;
         issue(pick_random(phase, level));
         pace();
      end

      push <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
